>>> hdl/smmt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smmt_pkg: shared types and constants
// Widths, event codes and sequencer states for the min/max/mean tracker.
// ----------------------------------------------------------------------------
package smmt_pkg;

  localparam int ADC_BITS   = 10;
  localparam int CNT_W      = 7;
  localparam int MAX_WINDOW = 64;
  localparam int TOTAL_W    = 16;
  localparam int FRAC_BITS  = 4;
  localparam int MEAN_W     = 14;
  localparam int DVD_W      = TOTAL_W + FRAC_BITS;
  localparam int DIV_CNT_W  = $clog2(DVD_W + 1);

  localparam logic [ADC_BITS-1:0] FULL_SCALE = '1;
  localparam logic [CNT_W-1:0]    WIN_RESET  = CNT_W'(40);

  // event codes carried on the input tuser
  localparam logic [1:0] FUNC_SAMPLE = 2'd0;
  localparam logic [1:0] FUNC_START  = 2'd1;
  localparam logic [1:0] FUNC_STOP   = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_LOAD
  } smmt_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage : smmt_pkg
`default_nettype wire

>>> hdl/sample_min_max_mean_tracker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sample_min_max_mean_tracker: running min / max / window mean of ADC codes
// Voltmeter statistics engine built around a shared serial divider.
// ----------------------------------------------------------------------------
// Each input item is an event: tuser selects sample, start or stop, and tdata
// carries the 10-bit converter code. Every item yields exactly one result item
// with the statistics after that event. Start clears everything and presets
// the minimum to full scale; stop clears all but the running total. A sample
// taken while recording bumps the window count (restarting at one, with the
// total cleared, once it passes window_length), adds into a total that
// saturates at 65535, and updates max and the smallest nonzero code. The mean
// is floor(16 * total / count), saturated at 16383, computed by a restoring
// divider that yields one quotient bit per clock. A sample while recording
// starts the divider on accept and the mean is captured when it is done;
// other items skip the divider. Every item then loads the output register,
// waiting while an earlier result is untaken, and in_tready returns after
// that load. The output register lets the next item be accepted while a
// result still waits on out_tready. The user must write window_length
// through cfg_wr_en / cfg_wr_data only while no item is in flight; the block
// does not enforce this. 0 acts as 1 and values above 64 act as 64.
// ----------------------------------------------------------------------------
module sample_min_max_mean_tracker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration: window_length
  input  wire logic        cfg_wr_en,
  input  wire logic [6:0]  cfg_wr_data,
  // input items
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [9:0] sample_code, rest zero
  input  wire logic [1:0]  in_tuser,   // [1:0] func
  // result items
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,  // [9:0] last_code, [23:10] mean_q4,
                                       // [33:24] max_code, [43:34] min_code,
                                       // [50:44] sample_count, rest zero
  output logic             out_tuser   // [0] recording
);
  import smmt_pkg::*;

  localparam int OUT_W = 56;
  localparam int PAY_W = ADC_BITS + MEAN_W + ADC_BITS + ADC_BITS + CNT_W;

  smmt_state_t state_r, state_nxt;

  // statistics
  logic                rec_r, rec_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [TOTAL_W-1:0]  total_r, total_nxt;
  logic [ADC_BITS-1:0] min_r, min_nxt;
  logic [ADC_BITS-1:0] max_r, max_nxt;
  logic [ADC_BITS-1:0] last_r, last_nxt;
  logic [MEAN_W-1:0]   mean_r, mean_nxt;
  logic [CNT_W-1:0]    win_r;

  // output register
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]    out_data_r;
  logic                out_user_r;

  logic                in_acc;
  logic [1:0]          func;
  logic [ADC_BITS-1:0] code;
  logic                take;
  logic [CNT_W-1:0]    win_eff;
  logic [CNT_W-1:0]    cnt_inc;
  logic                wrap;
  logic [TOTAL_W:0]    sum;
  logic [TOTAL_W-1:0]  total_new;
  logic [CNT_W-1:0]    cnt_new;

  logic                div_start;
  logic                out_load;
  logic [DVD_W-1:0]    quotient;
  div_stat_t           div_stat;

  assign func   = in_tuser;
  assign code   = in_tdata[ADC_BITS-1:0];
  assign in_acc = in_tvalid && in_tready;
  assign take   = in_acc && (func == FUNC_SAMPLE) && rec_r;

  // window length clamp
  always_comb begin
    if (win_r == '0) begin
      win_eff = CNT_W'(1);
    end else if (win_r > CNT_W'(MAX_WINDOW)) begin
      win_eff = CNT_W'(MAX_WINDOW);
    end else begin
      win_eff = win_r;
    end
  end

  assign cnt_inc   = cnt_r + CNT_W'(1);
  assign wrap      = cnt_inc > win_eff;
  assign cnt_new   = wrap ? CNT_W'(1) : cnt_inc;
  assign sum       = {1'b0, (wrap ? TOTAL_W'(0) : total_r)} + (TOTAL_W + 1)'(code);
  assign total_new = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];

  // statistics update on accept; mean lands when the divider finishes
  always_comb begin
    rec_nxt   = rec_r;
    cnt_nxt   = cnt_r;
    total_nxt = total_r;
    min_nxt   = min_r;
    max_nxt   = max_r;
    last_nxt  = last_r;
    mean_nxt  = mean_r;
    if (in_acc) begin
      case (func)
        FUNC_START: begin
          rec_nxt   = 1'b1;
          cnt_nxt   = '0;
          total_nxt = '0;
          min_nxt   = FULL_SCALE;
          max_nxt   = '0;
          last_nxt  = '0;
          mean_nxt  = '0;
        end
        FUNC_STOP: begin
          rec_nxt  = 1'b0;
          cnt_nxt  = '0;
          min_nxt  = '0;
          max_nxt  = '0;
          last_nxt = '0;
          mean_nxt = '0;
        end
        FUNC_SAMPLE: begin
          if (rec_r) begin
            cnt_nxt   = cnt_new;
            total_nxt = total_new;
            last_nxt  = code;
            if ((code != '0) && (code < min_r)) min_nxt = code;
            if (code > max_r) max_nxt = code;
          end
        end
        default: begin
        end
      endcase
    end
    if ((state_r == ST_DIV) && div_stat.done) begin
      mean_nxt = (|quotient[DVD_W-1:MEAN_W]) ? '1 : quotient[MEAN_W-1:0];
    end
  end

  smmt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({total_new, FRAC_BITS'(0)}),
    .divisor  (cnt_new),
    .quotient (quotient),
    .stat     (div_stat)
  );

  // sequencer: next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = take ? ST_DIV : ST_LOAD;
      end
      ST_DIV: begin
        if (div_stat.done) state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    in_tready = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        div_start = take;
      end
      ST_DIV: begin
      end
      ST_LOAD: begin
        out_load = !out_valid_r || out_tready;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rec_r       <= 1'b0;
      cnt_r       <= '0;
      total_r     <= '0;
      min_r       <= '0;
      max_r       <= '0;
      last_r      <= '0;
      mean_r      <= '0;
      win_r       <= WIN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rec_r       <= rec_nxt;
      cnt_r       <= cnt_nxt;
      total_r     <= total_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      last_r      <= last_nxt;
      mean_r      <= mean_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) win_r <= cfg_wr_data;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {(OUT_W - PAY_W)'(0), cnt_r, min_r, max_r, mean_r, last_r};
      out_user_r <= rec_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
  a_ready_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !div_stat.busy)
    else $error("input ready while divider busy");

  a_done_to_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && div_stat.done) |=> (state_r == ST_LOAD))
    else $error("divider result not followed by output load");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_WINDOW))
    else $error("window count beyond maximum window");

  a_idle_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    !rec_r |-> (cnt_r == '0 && max_r == '0 && last_r == '0 && mean_r == '0))
    else $error("statistics not cleared while not recording");

endmodule : sample_min_max_mean_tracker
`default_nettype wire

>>> hdl/smmt_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smmt_div: restoring divider, one quotient bit per cycle
// Divides the scaled window total by the sample count.
// ----------------------------------------------------------------------------
module smmt_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [smmt_pkg::DVD_W-1:0] dividend,
  input  wire logic [smmt_pkg::CNT_W-1:0] divisor,
  output logic      [smmt_pkg::DVD_W-1:0] quotient,
  output smmt_pkg::div_stat_t             stat
);
  import smmt_pkg::*;

  logic [DVD_W-1:0]     quo_r, quo_nxt;
  logic [CNT_W:0]       rem_r, rem_nxt;
  logic [CNT_W-1:0]     dsr_r, dsr_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 done_r, done_nxt;
  logic [CNT_W:0]       rem_sh;
  logic                 ge;

  assign rem_sh = {rem_r[CNT_W-1:0], quo_r[DVD_W-1]};
  assign ge     = rem_sh >= {1'b0, dsr_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      dsr_nxt = divisor;
      cnt_nxt = DIV_CNT_W'(DVD_W);
    end else if (cnt_r != '0) begin
      quo_nxt  = {quo_r[DVD_W-2:0], ge};
      rem_nxt  = ge ? (rem_sh - {1'b0, dsr_r}) : rem_sh;
      cnt_nxt  = cnt_r - DIV_CNT_W'(1);
      done_nxt = (cnt_r == DIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign quotient  = quo_r;
  assign stat.busy = (cnt_r != '0);
  assign stat.done = done_r;

endmodule : smmt_div
`default_nettype wire
